@@ sv/aes_sb_pkg.sv @@
package aes_sb_pkg;

    localparam logic [8:0] GF_MODULUS   = 9'h11B;  // x^8 + x^4 + x^3 + x + 1
    localparam logic [7:0] AFFINE_ROW0  = 8'hF1;
    localparam logic [7:0] AFFINE_CONST = 8'h63;

    typedef logic [3:0] deg_t;

    // status from the inversion unit back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } inv_status_t;

    // degree of a nonzero 9-bit binary polynomial
    function automatic deg_t poly_deg(input logic [8:0] p);
        deg_t d;
        d = '0;
        for (int i = 0; i < 9; i++)
        begin
            if (p[i])
            begin
                d = deg_t'(i);
            end
        end
        return d;
    endfunction

    // AES affine map: circulant bit matrix over GF(2), then add the constant
    function automatic logic [7:0] affine(input logic [7:0] x);
        logic [7:0] res;
        logic [7:0] row;
        res = '0;
        for (int i = 0; i < 8; i++)
        begin
            row    = (AFFINE_ROW0 << i) | (AFFINE_ROW0 >> (8 - i));
            res[i] = ^(row & x);
        end
        return res ^ AFFINE_CONST;
    endfunction

endpackage

@@ sv/aes_sb_inv.sv @@
module aes_sb_inv (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [7:0]               in_byte,
    output aes_sb_pkg::inv_status_t  status,
    output logic [7:0]               inv_byte
);
    import aes_sb_pkg::*;

    // remainders and their Bezout coefficients: r == t * in_byte (mod m)
    logic [8:0] a_reg, a_next;
    logic [8:0] b_reg, b_next;
    logic [8:0] ta_reg, ta_next;
    logic [8:0] tb_reg, tb_next;
    logic       run_reg, run_next;

    deg_t       deg_a;
    deg_t       deg_b;
    deg_t       shamt;
    logic       a_ge_b;
    logic       finished;

    assign deg_a    = poly_deg(a_reg);
    assign deg_b    = poly_deg(b_reg);
    assign a_ge_b   = (deg_a >= deg_b);
    assign shamt    = a_ge_b ? (deg_a - deg_b) : (deg_b - deg_a);
    // stop as soon as one remainder reaches one; a zero input starts with b at zero
    assign finished = (a_reg == 9'd1) || (b_reg == 9'd1) || (b_reg == '0);

    assign status.busy = run_reg;
    assign status.done = run_reg && finished;
    // take the coefficient of the remainder that reached one; zero input leaves ta at zero
    assign inv_byte    = (b_reg == 9'd1) ? tb_reg[7:0] : ta_reg[7:0];

    always_comb
    begin
        a_next   = a_reg;
        b_next   = b_reg;
        ta_next  = ta_reg;
        tb_next  = tb_reg;
        run_next = run_reg;
        if (start)
        begin
            a_next   = GF_MODULUS;
            b_next   = {1'b0, in_byte};
            ta_next  = '0;
            tb_next  = 9'd1;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (finished)
            begin
                run_next = 1'b0;
            end
            else if (a_ge_b)
            begin
                // cancel the leading term of a with a shifted copy of b
                a_next  = a_reg ^ (b_reg << shamt);
                ta_next = ta_reg ^ (tb_reg << shamt);
            end
            else
            begin
                b_next  = b_reg ^ (a_reg << shamt);
                tb_next = tb_reg ^ (ta_reg << shamt);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        ta_reg <= ta_next;
        tb_reg <= tb_next;
    end

endmodule

@@ sv/aes_sbox_byte_substitution.sv @@
// Inputs zero and one need no inverter step before out_valid.
// Each cycle the shift-and-xor step of the Euclidean inverter removes at least
// one degree from the two remainders, until one of them reaches one.
// A new byte is accepted only in idle, after the previous result has been taken
// at the output.
// Reset (rst_n, async, active low) returns the sequencer to idle with no result pending.
module aes_sbox_byte_substitution (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] sbox_byte
);
    import aes_sb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } state_t;

    state_t      state_reg, state_next;
    logic [7:0]  sbox_reg, sbox_next;
    logic        start;
    inv_status_t inv_status;
    logic [7:0]  inv_byte;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign sbox_byte = sbox_reg;
    assign start     = in_valid && in_ready;

    aes_sb_inv u_inv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .in_byte  (in_byte),
        .status   (inv_status),
        .inv_byte (inv_byte)
    );

    always_comb
    begin
        state_next = state_reg;
        sbox_next  = sbox_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (inv_status.done)
                begin
                    sbox_next  = affine(inv_byte);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sbox_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sbox_reg  <= sbox_next;
        end
    end

    // the inverter finishes only while the sequencer waits for it
    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        inv_status.done |-> (state_reg == ST_RUN))
        else $error("inverter done outside run state");

    // an accepted request starts the inverter on the next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (inv_status.busy && !in_ready))
        else $error("accepted request did not start the inverter");

    // the inverter stays busy for the whole run state
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> inv_status.busy)
        else $error("run state without a busy inverter");

endmodule
